FILE: rtl/sine_tone_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Sine tone generator assertion macros
// Shorthand for the concurrent checks that watch the generator's ports.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_GENERATOR_UNIT_ASSERT_SVH
`define SINE_TONE_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STU_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stg_pkg.sv
// ----------------------------------------------------------------------------
// Sine tone generator package
// Shared constants, payload types and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

  // Audio and phase accumulator configuration.
  localparam int unsigned SampleRate   = 16000;
  localparam int unsigned QuarterDepth = 256;
  localparam int unsigned PhaseBits    = 32;
  localparam int unsigned QuarterIdxW  = $clog2(QuarterDepth);
  localparam int unsigned MsPerSecond  = 1000;
  localparam int unsigned Peak         = 32767;
  localparam int unsigned FullGain     = 256;

  // Widths of the sample counter and of the two quotients.
  localparam int unsigned CountW     = 21;
  localparam int unsigned StepQuotW  = 17;
  localparam int unsigned CountQuotW = 23;

  // The phase step is f * 2^PhaseBits / SampleRate, split into whole and fraction.
  localparam logic [63:0] PhaseOne  = 64'd1 << PhaseBits;
  localparam logic [31:0] StepWhole = 32'(PhaseOne / SampleRate);
  localparam logic [31:0] StepFrac  = 32'(PhaseOne % SampleRate);
  localparam logic [31:0] HalfRate  = 32'(SampleRate / 2);

  // Pi/2 in Q60.
  localparam logic [63:0] HalfPiQ60 = 64'h1921FB54442D1847;

  typedef enum logic {
    MODE_TONE = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] tone_frequency;
    logic [15:0] duration_ms;
    logic [8:0]  volume;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               playing;
    logic               last_sample;
  } out_item_t;

  // What the state stage hands to the sample shaper.
  typedef struct packed {
    logic                   active;
    logic                   last;
    logic [1:0]             quadrant;
    logic [QuarterIdxW-1:0] index;
    logic [8:0]             gain;
  } lookup_t;

  // Load enables for a two-register section of the pipeline.
  typedef struct packed {
    logic first;
    logic second;
  } pipe_en_t;

  typedef logic [QuarterDepth-1:0][14:0] quarter_tab_t;

  // floor(a * b / 2^60), kept to 64 bits.
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // floor(num / den) by shift and subtract, one quotient bit per step.
  // The divisor is small, so the partial remainder never overflows.
  function automatic logic [63:0] div_small(logic [63:0] num, logic [63:0] den);
    logic [63:0] quot;
    logic [63:0] rem;
    quot = '0;
    rem  = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem     = rem - den;
        quot[i] = 1'b1;
      end
    end
    return quot;
  endfunction

  // round(32767 * sin(pi/2 * k / QuarterDepth)) by a Q60 Taylor series.
  function automatic logic [14:0] sine_entry(int unsigned k);
    logic [63:0] kk;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] den;
    logic [63:0] rounded;
    int unsigned n;
    kk   = 64'(k);
    x    = (HalfPiQ60 / QuarterDepth) * kk + ((HalfPiQ60 % QuarterDepth) * kk) / QuarterDepth;
    x2   = mul_q60(x, x);
    sum  = x;
    term = x;
    for (n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        den  = 64'(2 * n) * 64'(2 * n + 1);
        term = div_small(mul_q60(term, x2), den);
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    rounded = mul_q60(sum, 64'(2 * Peak)) + 64'd1;
    return 15'(rounded >> 1);
  endfunction

  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t tab;
    for (int unsigned k = 0; k < QuarterDepth; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam quarter_tab_t SineQuarter = build_quarter_tab();

endpackage

`default_nettype wire

FILE: rtl/stg_cdiv.sv
// ----------------------------------------------------------------------------
// Constant divider
// Two-stage reciprocal division of a 32-bit value by a fixed divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_cdiv
  import stg_pkg::*;
#(
  parameter int unsigned DIVISOR = SampleRate,
  parameter int unsigned QUOT_W  = StepQuotW
) (
  input  wire logic              clk_i,
  input  pipe_en_t               en_i,
  input  wire logic [31:0]       x_i,
  output logic      [QUOT_W-1:0] quot_o
);

  localparam logic [31:0] Recip  = 32'((64'd1 << 32) / DIVISOR);
  localparam logic [31:0] DivVal = 32'(DIVISOR);

  logic [31:0]       x_est_q;
  logic [QUOT_W-1:0] est_q;
  logic [QUOT_W-1:0] est_d;
  logic [63:0]       recip_prod;
  logic [31:0]       x_prod_q;
  logic [QUOT_W-1:0] est_prod_q;
  logic [31:0]       prod_q;
  logic [31:0]       prod_d;
  logic [31:0]       rem;

  // Estimate: floor(x * floor(2^32 / D) / 2^32) is the quotient or one below it.
  assign recip_prod = 64'(x_i) * 64'(Recip);
  assign est_d      = QUOT_W'(recip_prod[63:32]);

  // Multiply the estimate back to find the remainder.
  assign prod_d = 32'(32'(est_q) * DivVal);

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      x_est_q <= x_i;
      est_q   <= est_d;
    end
    if (en_i.second) begin
      x_prod_q   <= x_est_q;
      est_prod_q <= est_q;
      prod_q     <= prod_d;
    end
  end

  // One correction step brings the remainder below the divisor.
  assign rem    = x_prod_q - prod_q;
  assign quot_o = est_prod_q + QUOT_W'(rem >= DivVal);

endmodule

`default_nettype wire

FILE: rtl/stg_shaper.sv
// ----------------------------------------------------------------------------
// Sample shaper
// Quarter-wave table lookup, gain scaling and sign for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_shaper
  import stg_pkg::*;
(
  input  wire logic clk_i,
  input  pipe_en_t  en_i,
  input  lookup_t   lookup_i,
  output out_item_t result_o
);

  logic [QuarterIdxW-1:0] mirror_idx;
  logic [14:0]            tab_d;
  logic [14:0]            tab_q;
  logic                   neg_q;
  logic [8:0]             gain_q;
  logic                   active_q;
  logic                   last_q;
  logic [23:0]            scaled;
  logic [15:0]            mag;
  out_item_t              result_d;
  out_item_t              result_q;

  // Odd quadrants read the table backwards; index zero there is the peak.
  assign mirror_idx = QuarterIdxW'(~lookup_i.index + 1'b1);

  always_comb begin
    tab_d = '0;
    if (lookup_i.active) begin
      if (lookup_i.quadrant[0]) begin
        if (lookup_i.index == '0) begin
          tab_d = 15'(Peak);
        end else begin
          tab_d = SineQuarter[mirror_idx];
        end
      end else begin
        tab_d = SineQuarter[lookup_i.index];
      end
    end
  end

  // Scale by the gain, truncate the magnitude, then apply the sign.
  assign scaled = 24'(tab_q) * 24'(gain_q);
  assign mag    = scaled[23:8];

  always_comb begin
    result_d.sample      = neg_q ? (16'sd0 - $signed(mag)) : $signed(mag);
    result_d.playing     = active_q;
    result_d.last_sample = last_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      tab_q    <= tab_d;
      neg_q    <= lookup_i.quadrant[1];
      gain_q   <= lookup_i.gain;
      active_q <= lookup_i.active;
      last_q   <= lookup_i.last;
    end
    if (en_i.second) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: rtl/sine_tone_generator_unit.sv
// A sine tone generator built on direct digital synthesis. A tone request
// (mode 0) sets the frequency, the length in milliseconds and the gain, and
// returns no result; every sample tick (mode 1) returns one 16-bit PCM sample,
// silence when no tone is active. The block takes one request per clock cycle
// while in_stall_o is low. Requests travel a seven-register pipeline, in
// which the tone request's phase step and sample count are divided by
// constants through a reciprocal multiply and a correction step over three
// stages, the phase and sample count live in stage four, and the table lookup
// and the gain multiply take the last two. A stalled output only holds the
// stages behind it that are full; empty stages keep filling.
// ----------------------------------------------------------------------------
// Sine tone generator top level
// Request pipeline, tone state and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_tone_generator_unit
  import stg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [CountQuotW-1:0] CountMax = CountQuotW'((1 << CountW) - 1);

  // Stage valid bits and the ready chain.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  // Stage payloads.
  in_item_t             in_q;
  mode_e                mode2_q, mode3_q, mode4_q;
  logic [PhaseBits-1:0] whole2_q, whole3_q, whole4_q;
  logic [8:0]           gain2_q, gain3_q, gain4_q;
  logic [31:0]          step_x2_q, count_x2_q;
  lookup_t              lookup_q, lookup_d;

  // First-stage products.
  logic [47:0]          whole_prod;
  logic [PhaseBits-1:0] whole_d;
  logic [31:0]          step_x_d;
  logic [31:0]          count_x_d;
  logic [8:0]           gain_d;

  // Divider results and the new tone settings.
  logic [StepQuotW-1:0]  step_quot;
  logic [CountQuotW-1:0] count_quot;
  logic [PhaseBits-1:0]  step_new;
  logic [CountW-1:0]     count_new;

  // Tone state.
  logic [PhaseBits-1:0] phase_acc_q, phase_acc_d;
  logic [PhaseBits-1:0] phase_step_q, phase_step_d;
  logic [CountW-1:0]    samples_left_q, samples_left_d;
  logic [8:0]           tone_gain_q, tone_gain_d;
  logic                 fire4;

  pipe_en_t div_en;
  pipe_en_t shape_en;

  // A stage may load when it is empty or its content moves on; a tone request
  // leaves the pipeline at the state stage.
  assign rdy7 = !v7_q || !out_stall_i;
  assign rdy6 = !v6_q || rdy7;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || (mode4_q == MODE_TONE) || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign fire4 = v4_q && rdy4;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy5) begin
        v5_q <= v4_q && (mode4_q == MODE_TICK);
      end
      if (rdy6) begin
        v6_q <= v5_q;
      end
      if (rdy7) begin
        v7_q <= v6_q;
      end
    end
  end

  // Whole part of the phase step, the fraction to be rounded, the sample
  // count numerator and the saturated gain.
  assign whole_prod = 48'(in_q.tone_frequency) * 48'(StepWhole);
  assign whole_d    = whole_prod[PhaseBits-1:0];
  assign step_x_d   = 32'(32'(in_q.tone_frequency) * StepFrac) + HalfRate;
  assign count_x_d  = 32'(32'(in_q.duration_ms) * 32'(SampleRate));
  assign gain_d     = (in_q.volume > 9'(FullGain)) ? 9'(FullGain) : in_q.volume;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      in_q <= in_data_i;
    end
    if (rdy2) begin
      mode2_q    <= in_q.mode;
      whole2_q   <= whole_d;
      gain2_q    <= gain_d;
      step_x2_q  <= step_x_d;
      count_x2_q <= count_x_d;
    end
    if (rdy3) begin
      mode3_q  <= mode2_q;
      whole3_q <= whole2_q;
      gain3_q  <= gain2_q;
    end
    if (rdy4) begin
      mode4_q  <= mode3_q;
      whole4_q <= whole3_q;
      gain4_q  <= gain3_q;
    end
    if (rdy5) begin
      lookup_q <= lookup_d;
    end
  end

  // Rounded fraction of the phase step and the length in samples.
  assign div_en.first  = rdy3;
  assign div_en.second = rdy4;

  stg_cdiv #(
    .DIVISOR(SampleRate),
    .QUOT_W (StepQuotW)
  ) u_step_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .x_i   (step_x2_q),
    .quot_o(step_quot)
  );

  stg_cdiv #(
    .DIVISOR(MsPerSecond),
    .QUOT_W (CountQuotW)
  ) u_count_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .x_i   (count_x2_q),
    .quot_o(count_quot)
  );

  assign step_new  = whole4_q + PhaseBits'(step_quot);
  assign count_new = (count_quot > CountMax) ? CountW'(CountMax) : count_quot[CountW-1:0];

  // Tone state: a request reloads it, an active tick advances it.
  always_comb begin
    phase_acc_d    = phase_acc_q;
    phase_step_d   = phase_step_q;
    samples_left_d = samples_left_q;
    tone_gain_d    = tone_gain_q;
    if (fire4) begin
      if (mode4_q == MODE_TONE) begin
        phase_step_d   = step_new;
        phase_acc_d    = '0;
        samples_left_d = count_new;
        tone_gain_d    = gain4_q;
      end else if (samples_left_q != '0) begin
        phase_acc_d    = phase_acc_q + phase_step_q;
        samples_left_d = samples_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q    <= '0;
      phase_step_q   <= '0;
      samples_left_q <= '0;
      tone_gain_q    <= '0;
    end else begin
      phase_acc_q    <= phase_acc_d;
      phase_step_q   <= phase_step_d;
      samples_left_q <= samples_left_d;
      tone_gain_q    <= tone_gain_d;
    end
  end

  // Quadrant and table index come from the top phase bits.
  always_comb begin
    lookup_d.active   = (samples_left_q != '0);
    lookup_d.last     = (samples_left_q == CountW'(1));
    lookup_d.quadrant = phase_acc_q[PhaseBits-1 -: 2];
    lookup_d.index    = phase_acc_q[PhaseBits-3 -: QuarterIdxW];
    lookup_d.gain     = tone_gain_q;
  end

  // Table lookup and scaling into the output register.
  assign shape_en.first  = rdy6;
  assign shape_en.second = rdy7;

  stg_shaper u_shaper (
    .clk_i   (clk_i),
    .en_i    (shape_en),
    .lookup_i(lookup_q),
    .result_o(out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/stg_checker.sv
// ----------------------------------------------------------------------------
// Sine tone generator checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sine_tone_generator_unit_assert.svh"

module stg_checker
  import stg_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_stall_i,
  input out_item_t out_data_i
);

  // A stalled result stays offered and unchanged.
  `STU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "stalled result changed or dropped")

  // The final sample of a tone belongs to that tone.
  `STU_ASSERT_HOLDS(a_last_playing, clk_i, rst_ni, out_valid_i && out_data_i.last_sample, out_data_i.playing, "last sample flagged outside a tone")

  // Idle ticks are silent.
  `STU_ASSERT_HOLDS(a_idle_silent, clk_i, rst_ni, out_valid_i && !out_data_i.playing, out_data_i.sample == 16'sd0, "idle tick gave a nonzero sample")

  // The scaled sine never reaches the most negative code.
  `STU_ASSERT_HOLDS(a_sample_range, clk_i, rst_ni, out_valid_i, out_data_i.sample != 16'sh8000, "sample outside the symmetric range")

endmodule

bind sine_tone_generator_unit stg_checker u_stg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);

`default_nettype wire

FILE: sim/sine_tone_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sine tone generator testbench
// Drives tone requests and sample ticks through the valid/stall handshake.
// An in-bench tone model predicts every sample, and each returned sample is
// checked field by field. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------

module sine_tone_generator_unit_tb;
  import stg_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned ReportMax   = 10;
  localparam real         HalfPi      = 1.5707963267948966;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // Tone state of the in-bench model.
  logic [31:0] tone_phase;
  logic [31:0] tone_step;
  logic [20:0] tone_left;
  logic [8:0]  tone_gain;
  logic [14:0] sine_quarter_q [QuarterDepth];

  out_item_t   expected_samples [$];
  int unsigned sent_count;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;

  sine_tone_generator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Applies one request to the tone model and queues the sample it yields.
  function automatic void predict_tone(in_item_t req);
    logic [63:0] step_wide;
    logic [31:0] count;
    logic [1:0]  quad;
    logic [7:0]  k;
    logic [15:0] amp;
    logic [24:0] scaled;
    logic [15:0] mag;
    out_item_t   smp;
    if (req.mode == MODE_TONE) begin
      // Rounded phase step, wrapped to the accumulator width.
      step_wide  = (({48'd0, req.tone_frequency} << PhaseBits) + 64'(SampleRate / 2))
                   / 64'(SampleRate);
      count      = (32'(SampleRate) * 32'(req.duration_ms)) / 32'(MsPerSecond);
      tone_step  = step_wide[31:0];
      tone_phase = '0;
      tone_left  = (count > 32'h1F_FFFF) ? 21'h1F_FFFF : count[20:0];
      tone_gain  = (req.volume > 9'(FullGain)) ? 9'(FullGain) : req.volume;
    end else begin
      smp = '0;
      if (tone_left != '0) begin
        quad = tone_phase[31:30];
        k    = tone_phase[29:22];
        // Odd quadrants read the table backwards; the start of one is the peak.
        if (quad[0]) begin
          amp = (k == 8'd0) ? 16'(Peak) : {1'b0, sine_quarter_q[QuarterDepth - int'(k)]};
        end else begin
          amp = {1'b0, sine_quarter_q[k]};
        end
        scaled = 25'(amp) * 25'(tone_gain);
        mag    = scaled[23:8];
        smp.sample      = quad[1] ? 16'(16'd0 - mag) : mag;
        smp.playing     = 1'b1;
        smp.last_sample = (tone_left == 21'd1);
        tone_phase      = tone_phase + tone_step;
        tone_left       = tone_left - 21'd1;
      end
      expected_samples.push_back(smp);
    end
  endfunction

  function automatic in_item_t make_tone(int unsigned freq, int unsigned ms, int unsigned vol);
    in_item_t req;
    req.mode           = MODE_TONE;
    req.tone_frequency = 16'(freq);
    req.duration_ms    = 16'(ms);
    req.volume         = 9'(vol);
    return req;
  endfunction

  // A tick carries random values in the fields that it ignores.
  function automatic in_item_t make_tick();
    in_item_t req;
    req      = in_item_t'(42'({$urandom(), $urandom()}));
    req.mode = MODE_TICK;
    return req;
  endfunction

  // Sends one request, with random idle cycles ahead of it, and waits for it
  // to be taken.
  task automatic send_request(in_item_t req);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_tone(req);
    sent_count++;
  endtask

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= ReportMax) begin
      $display("%0t: %s: expected sample %0d playing %0b last %0b, got %0d %0b %0b",
               $realtime, what, want.sample, want.playing, want.last_sample,
               got.sample, got.playing, got.last_sample);
    end
  endtask

  // Compares every accepted sample with the oldest prediction.
  always @(posedge clk_i) begin : check_samples
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("sample with none expected", '0, out_data_o);
      end else begin
        want = expected_samples.pop_front();
        if (out_data_o.sample !== want.sample || out_data_o.playing !== want.playing ||
            out_data_o.last_sample !== want.last_sample) begin
          report_mismatch("sample mismatch", want, out_data_o);
        end
      end
    end
  end

  // Ends the run if neither side moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A tick right after reset gives silence.
  task automatic test_idle_silence();
    send_request('{mode: MODE_TICK, tone_frequency: '1, duration_ms: '1, volume: '1});
  endtask

  // A quarter-rate tone lands each tick on a quadrant boundary. Gain above
  // full scale saturates, and the tone runs out with its last sample marked.
  task automatic test_quadrant_walk();
    send_request(make_tone(4000, 1, 257));
    repeat (17) send_request(make_tick());
  endtask

  // Extreme frequency, duration and gain; each tone replaces the one before.
  task automatic test_extreme_tones();
    send_request(make_tone(65535, 65535, 0));
    send_request(make_tick());
    send_request(make_tone(0, 1, 256));
    send_request(make_tick());
    send_request(make_tone(4000, 0, 511));
    send_request(make_tick());
  endtask

  // Random tones, each followed by a run of ticks that mostly reaches past
  // its end; some runs are cut short by the next tone.
  task automatic play_random_tones(int unsigned n_items);
    int unsigned target;
    int unsigned ms;
    int unsigned vol;
    int unsigned freq;
    int unsigned planned;
    int unsigned n_ticks;
    target = sent_count + n_items;
    while (sent_count < target) begin
      case ($urandom_range(9))
        0:       freq = $urandom_range(3) * 4000;
        1, 2:    freq = $urandom_range(65535);
        default: freq = $urandom_range(8000);
      endcase
      case ($urandom_range(19))
        0:       ms = 0;
        1:       ms = 65535;
        2:       ms = $urandom_range(65535);
        default: ms = $urandom_range(3);
      endcase
      case ($urandom_range(7))
        0:       vol = 256;
        1:       vol = 0;
        default: vol = $urandom_range(511);
      endcase
      planned = (SampleRate * ms) / MsPerSecond;
      case ($urandom_range(7))
        0:       n_ticks = $urandom_range((planned > 40) ? 40 : planned);
        1:       n_ticks = 0;
        default: n_ticks = (planned > 60) ? $urandom_range(60) : planned + $urandom_range(2);
      endcase
      send_request(make_tone(freq, ms, vol));
      repeat (n_ticks) send_request(make_tick());
    end
  endtask

  task automatic test_no_idling();
    gap_pct   = 0;
    stall_pct = 0;
    play_random_tones(355);
  endtask

  task automatic test_sender_gaps();
    gap_pct   = 54;
    stall_pct = 0;
    play_random_tones(355);
  endtask

  task automatic test_receiver_stalls();
    gap_pct   = 0;
    stall_pct = 54;
    play_random_tones(355);
  endtask

  task automatic test_both_idling();
    gap_pct   = 35;
    stall_pct = 35;
    play_random_tones(355);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    gap_pct        = 0;
    stall_pct      = 0;
    sent_count     = 0;
    mismatch_count = 0;
    tone_phase     = '0;
    tone_step      = '0;
    tone_left      = '0;
    tone_gain      = '0;
    // Quarter-wave table: round(32767 * sin(pi/2 * k / depth)).
    for (int k = 0; k < QuarterDepth; k++) begin
      sine_quarter_q[k] = 15'($rtoi(32767.0 * $sin(HalfPi * k / QuarterDepth) + 0.5));
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_silence();
    test_quadrant_walk();
    test_extreme_tones();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idling();

    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
